### hw/rtl/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Types, codes and sizes shared by the positional ordered list block.
// ----------------------------------------------------------------------------
package pol_pkg;

  localparam int DEPTH    = 16;
  localparam int ID_W     = 32;
  localparam int POS_W    = 5;
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_POS_ERR  = 2'd1,
    ST_NOTFOUND = 2'd2,
    ST_FULL     = 2'd3
  } stat_t;

  typedef struct packed {
    op_t              opcode;
    logic [POS_W-1:0] position;
    logic [31:0]      window_id;
  } in_req_t;

  typedef struct packed {
    stat_t            status;
    logic [31:0]      removed_id;
    logic [POS_W-1:0] found_index;
    logic [POS_W-1:0] entry_count;
  } out_rsp_t;

  typedef enum logic [1:0] {
    FSM_IDLE = 2'd0,
    FSM_EXEC = 2'd1,
    FSM_RESP = 2'd2
  } fsm_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;   // latch the accepted request
    logic exec;      // update the list, compare the row
    logic load_out;  // write the output register
  } pol_cmd_t;

endpackage

### hw/rtl/positional_ordered_list_core.sv
// ----------------------------------------------------------------------------
// positional_ordered_list_core
// Ordered list of window identifiers with insert, delete, find and clear.
// ----------------------------------------------------------------------------
// Each request passes through an execute state, in which the row of sixteen
// entry cells shifts in parallel (insert/delete) and is compared against the
// identifier, and a response state, in which the first hit is encoded and
// the response written to the output register. A new request is taken in the
// response state as long as the output register is free or being drained, so
// a new request is never accepted before the last one reaches that state; a
// stalled output holds the sequencer in its response state. Every request
// yields exactly one response carrying the entry count after the operation.
// ----------------------------------------------------------------------------
module positional_ordered_list_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pol_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output pol_pkg::out_rsp_t out_data
);
  import pol_pkg::*;

  pol_cmd_t cmd;

  // sequencer: idle -> exec -> resp
  pol_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // entry row, count and response register
  pol_dpath u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

  // an accepted request is executed in the very next cycle
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> cmd.exec)
    else $error("accepted request not executed");

  // execution never repeats on consecutive cycles
  a_exec_single: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> !cmd.exec)
    else $error("back-to-back execute");

  // a loaded response is presented
  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> out_valid)
    else $error("response loaded but not valid");

  // the count never exceeds the list depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.entry_count <= POS_W'(DEPTH)))
    else $error("entry count out of range");

endmodule

### hw/rtl/pol_ctrl.sv
// ----------------------------------------------------------------------------
// pol_ctrl
// Sequencer: accept, execute, respond; owns the handshakes.
// ----------------------------------------------------------------------------
module pol_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output pol_pkg::pol_cmd_t cmd
);
  import pol_pkg::*;

  fsm_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FSM_IDLE: begin
        if (in_valid) state_nxt = FSM_EXEC;
      end
      FSM_EXEC: begin
        state_nxt = FSM_RESP;
      end
      FSM_RESP: begin
        if (out_free) state_nxt = in_valid ? FSM_EXEC : FSM_IDLE;
      end
      default: begin
        state_nxt = FSM_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready     = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    unique case (state_r)
      FSM_IDLE: begin
        in_ready = 1'b1;
      end
      FSM_EXEC: begin
        cmd.exec = 1'b1;
      end
      FSM_RESP: begin
        cmd.load_out = out_free;
        in_ready     = out_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
    cmd.capture = in_valid && in_ready;
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

### hw/rtl/pol_dpath.sv
// ----------------------------------------------------------------------------
// pol_dpath
// Row of entry cells with parallel shift and compare, count and result regs.
// ----------------------------------------------------------------------------
module pol_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  pol_pkg::pol_cmd_t cmd,
  input  pol_pkg::in_req_t  in_data,
  output pol_pkg::out_rsp_t out_data
);
  import pol_pkg::*;

  // latched request
  op_t              op_r;
  logic [POS_W-1:0] pos_r;
  logic [ID_W-1:0]  id_r;

  logic [ID_W-1:0]  ent_r   [DEPTH];
  logic [ID_W-1:0]  ent_nxt [DEPTH];
  logic [CNT_W-1:0] count_r, count_nxt;

  logic [DEPTH-1:0] match_r, match_nxt;
  stat_t            stat_r, stat_nxt;
  logic [ID_W-1:0]  rem_r, rem_nxt;
  out_rsp_t         out_r, out_nxt;

  logic [CMP_W-1:0] pos_c, cnt_c, pos_m1;
  logic             ins_ok, del_ok;
  logic [IDX_W-1:0] rd_idx;
  logic             any_hit;
  logic [POS_W-1:0] hit_idx;

  assign pos_c  = CMP_W'(pos_r);
  assign cnt_c  = CMP_W'(count_r);
  assign pos_m1 = pos_c - CMP_W'(1);
  assign rd_idx = pos_m1[IDX_W-1:0];
  assign ins_ok = (pos_c <= cnt_c) && (count_r != CNT_W'(DEPTH));
  assign del_ok = (pos_r != '0) && (pos_c <= cnt_c);

  always_comb begin
    for (int i = 0; i < DEPTH; i++) begin
      ent_nxt[i]   = ent_r[i];
      match_nxt[i] = (ent_r[i] == id_r) && (CMP_W'(i) < cnt_c);
      if (cmd.exec && op_r == OP_INSERT && ins_ok) begin
        if (CMP_W'(i) == pos_c) ent_nxt[i] = id_r;
        else if (i > 0 && CMP_W'(i) > pos_c) ent_nxt[i] = ent_r[(i > 0) ? i - 1 : 0];
      end else if (cmd.exec && op_r == OP_DELETE && del_ok) begin
        if (i < DEPTH - 1 && CMP_W'(i) >= pos_m1)
          ent_nxt[i] = ent_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    stat_nxt  = ST_OK;
    rem_nxt   = '0;
    case (op_r)
      OP_INSERT: begin
        if (pos_c > cnt_c) stat_nxt = ST_POS_ERR;
        else if (count_r == CNT_W'(DEPTH)) stat_nxt = ST_FULL;
        else count_nxt = count_r + CNT_W'(1);
      end
      OP_DELETE: begin
        if (!del_ok) begin
          stat_nxt = ST_POS_ERR;
        end else begin
          rem_nxt   = ent_r[rd_idx];
          count_nxt = count_r - CNT_W'(1);
        end
      end
      OP_CLEAR: begin
        count_nxt = '0;
      end
      default: begin
        stat_nxt = ST_OK;
      end
    endcase
  end

  // first hit, lowest index wins
  always_comb begin
    hit_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_r[i]) hit_idx = POS_W'(i + 1);
    end
  end
  assign any_hit = |match_r;

  always_comb begin
    out_nxt             = out_r;
    out_nxt.entry_count = POS_W'(count_r);
    out_nxt.removed_id  = 32'(rem_r);
    if (op_r == OP_FIND) begin
      out_nxt.status      = any_hit ? ST_OK : ST_NOTFOUND;
      out_nxt.found_index = hit_idx;
    end else begin
      out_nxt.status      = stat_r;
      out_nxt.found_index = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_r  <= in_data.opcode;
      pos_r <= in_data.position;
      id_r  <= in_data.window_id[ID_W-1:0];
    end
    if (cmd.exec) begin
      ent_r   <= ent_nxt;
      match_r <= match_nxt;
      stat_r  <= stat_nxt;
      rem_r   <= rem_nxt;
    end
    if (cmd.load_out) out_r <= out_nxt;
  end

  assign out_data = out_r;

endmodule

### tb/pol_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// pol_checker
// Watches both channels of the ordered list, predicts every response from
// its own copy of the list, and compares each response field by field.
// ----------------------------------------------------------------------------
module pol_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  pol_pkg::in_req_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  pol_pkg::out_rsp_t out_data,
  output int                fail_count,
  output int                pending,
  output int                model_fill,
  output int                rsp_checked,
  output int                pos_errs,
  output int                misses,
  output int                fulls
);

  import pol_pkg::*;

  logic [ID_W-1:0] slot_q [DEPTH];
  int              fill_q;
  out_rsp_t        expected_rsp_q [$];

  initial begin
    fail_count  = 0;
    pending     = 0;
    model_fill  = 0;
    rsp_checked = 0;
    pos_errs    = 0;
    misses      = 0;
    fulls       = 0;
    fill_q      = 0;
  end

  // Apply one request to the shadow list and work out its response.
  task automatic apply_list_op(input in_req_t r, output out_rsp_t rsp);
    int i;
    rsp.status      = ST_OK;
    rsp.removed_id  = '0;
    rsp.found_index = '0;
    case (r.opcode)
      OP_INSERT: begin
        if (r.position > fill_q) begin
          rsp.status = ST_POS_ERR;
        end else if (fill_q >= DEPTH) begin
          rsp.status = ST_FULL;
        end else begin
          for (i = fill_q; i > r.position; i--) slot_q[i] = slot_q[i-1];
          slot_q[IDX_W'(r.position)] = r.window_id;
          fill_q++;
        end
      end
      OP_DELETE: begin
        if (r.position == 0 || r.position > fill_q) begin
          rsp.status = ST_POS_ERR;
        end else begin
          rsp.removed_id = slot_q[IDX_W'(r.position - 1)];
          for (i = r.position - 1; i + 1 < fill_q; i++) slot_q[i] = slot_q[i+1];
          fill_q--;
        end
      end
      OP_FIND: begin
        for (i = 0; i < fill_q; i++) begin
          if (rsp.found_index == 0 && slot_q[i] == r.window_id)
            rsp.found_index = POS_W'(i + 1);
        end
        if (rsp.found_index == 0) rsp.status = ST_NOTFOUND;
      end
      default: begin
        fill_q = 0;
      end
    endcase
    rsp.entry_count = POS_W'(fill_q);
  endtask

  always @(posedge clk) begin
    out_rsp_t exp_rsp;
    out_rsp_t new_rsp;
    if (!rst_n) begin
      expected_rsp_q.delete();
      fill_q = 0;
    end else begin
      // response side first: it can never belong to a request taken this edge
      if (out_valid && out_ready) begin
        if (expected_rsp_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("unexpected response: st=%0d rm=%h fi=%0d cnt=%0d",
                     out_data.status, out_data.removed_id,
                     out_data.found_index, out_data.entry_count);
        end else begin
          exp_rsp = expected_rsp_q.pop_front();
          rsp_checked++;
          case (exp_rsp.status)
            ST_POS_ERR:  pos_errs++;
            ST_NOTFOUND: misses++;
            ST_FULL:     fulls++;
            default: ;
          endcase
          if (out_data.status !== exp_rsp.status ||
              out_data.removed_id !== exp_rsp.removed_id ||
              out_data.found_index !== exp_rsp.found_index ||
              out_data.entry_count !== exp_rsp.entry_count) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"mismatch on response %0d: exp st=%0d rm=%h fi=%0d cnt=%0d,",
                        " got st=%0d rm=%h fi=%0d cnt=%0d"},
                       rsp_checked, exp_rsp.status, exp_rsp.removed_id,
                       exp_rsp.found_index, exp_rsp.entry_count,
                       out_data.status, out_data.removed_id,
                       out_data.found_index, out_data.entry_count);
          end
        end
      end
      if (in_valid && in_ready) begin
        apply_list_op(in_data, new_rsp);
        expected_rsp_q.push_back(new_rsp);
      end
    end
    pending    = expected_rsp_q.size();
    model_fill = fill_q;
  end

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the positional ordered list: a directed pass over
// the corner cases, then phased random traffic with idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  import pol_pkg::*;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_rsp_t out_data;

  int fail_count;
  int pending;
  int model_fill;
  int rsp_checked;
  int pos_errs;
  int misses;
  int fulls;

  int          sent_total;
  bit          steady;       // no idling on either side while set
  logic [31:0] id_pool [8];  // small pool so that finds actually hit

  positional_ordered_list_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  pol_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data),
    .fail_count  (fail_count),
    .pending     (pending),
    .model_fill  (model_fill),
    .rsp_checked (rsp_checked),
    .pos_errs    (pos_errs),
    .misses      (misses),
    .fulls       (fulls)
  );

  // 10 ns clock, low phase first
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Watchdog: allows well over the slowest legal run, then reports FAIL.
  initial begin
    #4_000_000;
    $display("FAIL");
    $finish;
  end

  // Result side: random ready/stall bursts of random length, held high
  // whenever the stimulus asks for a steady stretch.
  initial begin
    int burst_left;
    burst_left = 0;
    out_ready  = 1'b0;
    forever begin
      @(negedge clk);
      if (steady) begin
        out_ready  <= 1'b1;
        burst_left = 0;
      end else if (burst_left == 0) begin
        out_ready  <= ($urandom_range(0, 99) < 65);
        burst_left = $urandom_range(0, 13);
      end else begin
        burst_left--;
      end
    end
  end

  // Present one request from a falling edge and hold it until it is taken.
  // Returns at the falling edge after acceptance with in_valid still high,
  // so a back-to-back request simply overwrites the payload.
  task automatic send_req(input op_t op, input logic [4:0] pos, input logic [31:0] id);
    in_req_t r;
    r.opcode    = op;
    r.position  = pos;
    r.window_id = id;
    in_data  <= r;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_total++;
    @(negedge clk);
  endtask

  // Sender idle burst of random length, now and then.
  task automatic sender_gap();
    if (!steady && $urandom_range(0, 99) < 20) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  // Stop sending until every outstanding response has come back.
  task automatic drain_wait();
    in_valid <= 1'b0;
    wait (pending == 0);
    @(negedge clk);
  endtask

  // One random request; mode biases the mix: 0 fill, 1 drain, 2 mixed,
  // 3 search-heavy. Positions are mostly legal for the current fill.
  task automatic send_random(input int mode);
    int          roll;
    int          w_ins;
    int          w_del;
    op_t         op;
    logic [4:0]  pos;
    logic [31:0] id;
    case (mode)
      0:       begin w_ins = 65; w_del = 10; end
      1:       begin w_ins = 10; w_del = 65; end
      2:       begin w_ins = 35; w_del = 30; end
      default: begin w_ins = 20; w_del = 15; end
    endcase
    roll = $urandom_range(0, 99);
    if (roll < 3)                  op = OP_CLEAR;
    else if (roll < 3 + w_ins)     op = OP_INSERT;
    else if (roll < 3 + w_ins + w_del) op = OP_DELETE;
    else                           op = OP_FIND;

    if ($urandom_range(0, 4) == 0)
      pos = 5'($urandom_range(0, 31));
    else if (op == OP_DELETE && model_fill > 0)
      pos = 5'($urandom_range(1, model_fill));
    else
      pos = 5'($urandom_range(0, model_fill));

    if ($urandom_range(0, 19) == 0) id_pool[3'($urandom_range(0, 7))] = $urandom;
    if ($urandom_range(0, 99) < 70) id = id_pool[3'($urandom_range(0, 7))];
    else                            id = $urandom;

    send_req(op, pos, id);
    sender_gap();
  endtask

  initial begin
    int phase_len;
    int phase_mode;
    int k;

    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_data    = '0;
    steady     = 1'b0;
    sent_total = 0;
    for (k = 0; k < 8; k++) id_pool[k] = $urandom;

    repeat (7) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // --- directed corners -------------------------------------------------
    send_req(OP_FIND,   5'd0,  32'hDEAD_BEEF);  // find on empty list
    send_req(OP_DELETE, 5'd0,  32'hFFFF_FFFF);  // delete at position zero
    sender_gap();
    send_req(OP_INSERT, 5'd1,  32'h0000_0001);  // insert past end of empty list
    send_req(OP_INSERT, 5'd0,  32'h0000_0000);  // lowest identifier
    send_req(OP_INSERT, 5'd1,  32'hFFFF_FFFF);  // highest, at the tail
    send_req(OP_INSERT, 5'd0,  32'h1234_5678);  // at the front
    send_req(OP_FIND,   5'd31, 32'hFFFF_FFFF);  // hit at the tail, junk position
    send_req(OP_DELETE, 5'd31, 32'h5555_AAAA);  // delete far past the end
    send_req(OP_INSERT, 5'd31, 32'hAAAA_5555);  // insert far past the end
    send_req(OP_DELETE, 5'd2,  32'h0);          // middle delete, removes zero
    drain_wait();

    // fill to depth with repeating identifiers so find must pick the first
    steady = 1'b1;
    for (k = 0; k < DEPTH - 2; k++)
      send_req(OP_INSERT, 5'(model_fill / 2), 32'hA5A5_0000 | (k % 3));
    steady = 1'b0;
    send_req(OP_INSERT, 5'd16, 32'hCAFE_0001);  // full list, legal slot
    send_req(OP_INSERT, 5'd17, 32'hCAFE_0002);  // full list, bad slot: position wins
    send_req(OP_FIND,   5'd0,  32'hA5A5_0002);  // first of several matches
    send_req(OP_DELETE, 5'd16, 32'h0);          // last entry
    send_req(OP_CLEAR,  5'd31, 32'hFFFF_FFFF);  // clear with junk fields
    drain_wait();

    // --- random phases ----------------------------------------------------
    while (sent_total < 1730) begin
      phase_len  = $urandom_range(20, 120);
      phase_mode = $urandom_range(0, 3);
      // last couple of hundred requests run without idling
      steady = (sent_total > 1530) || ($urandom_range(0, 9) == 0);
      for (k = 0; k < phase_len && sent_total < 1730; k++)
        send_random(phase_mode);
      if (!steady && $urandom_range(0, 5) == 0) drain_wait();
    end

    // --- wind down --------------------------------------------------------
    in_valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);

    $display("Run covered %0d requests and %0d checked responses", sent_total, rsp_checked);
    $display("  incl. %0d position errors, %0d failed finds, %0d full-list inserts",
             pos_errs, misses, fulls);
    if (fail_count == 0 && pending == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
